[hdl/wfs_pkg.sv]
// shared types and constants for the word frequency sorter
`default_nettype none
package wfs_pkg;
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int RANK_W  = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic               upd;    // apply an update this cycle
    logic               ins;    // insert a new word
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] cnt;    // new count for the updated word
  } cell_ctl_t;

  // what one cell tells its lower neighbor
  typedef struct packed {
    logic               valid;
    logic               after;  // the moving entry ranks before this entry
    logic               match;  // this or an earlier cell holds the key
    logic [KEY_W-1:0]   word;
    logic [COUNT_W-1:0] cnt;
  } cell_link_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;
endpackage
`default_nettype wire

[hdl/wfs_cell.sv]
// one cell of the sorted table: holds one entry and shifts with its neighbor
`default_nettype none
module wfs_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wfs_pkg::cell_ctl_t ctl,
  input  wire wfs_pkg::cell_link_t prev,
  output wfs_pkg::cell_link_t     link
);
  logic                       valid_r, valid_nxt;
  logic [wfs_pkg::KEY_W-1:0]  word_r, word_nxt;
  logic [wfs_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic hit, outranks, after_here, match_here;

  // entry compares against the moving entry (key, cnt)
  assign hit      = valid_r && (word_r == ctl.key);
  assign outranks = !valid_r || (ctl.cnt > cnt_r) ||
                    ((ctl.cnt == cnt_r) && (ctl.key < word_r));
  // for increments only entries above the match shift; the moving entry
  // never outranks entries with count above its own, so outranks is monotone
  assign after_here = prev.after || (outranks && !hit);
  assign match_here = prev.match || hit;

  assign link = '{valid: valid_r, after: after_here, match: match_here,
                  word: word_r, cnt: cnt_r};

  // update: cells between new place and old place shift down by one
  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    if (ctl.upd) begin
      if (ctl.ins) begin
        if (after_here) begin
          valid_nxt = prev.after ? prev.valid : 1'b1;
          word_nxt  = prev.after ? prev.word  : ctl.key;
          cnt_nxt   = prev.after ? prev.cnt   : ctl.cnt;
        end
      end else if (after_here && !prev.match) begin
        word_nxt = prev.after ? prev.word : ctl.key;
        cnt_nxt  = prev.after ? prev.cnt  : ctl.cnt;
      end else if (hit && !prev.after) begin
        cnt_nxt = ctl.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
    cnt_r  <= cnt_nxt;
  end
endmodule
`default_nettype wire

[hdl/word_frequency_sorter_core.sv]
// top level of the word frequency sorter: sequencer and chain of cells
//
// Usage: raise start with in_command, in_word_key and in_rank while busy is
// low; the command is taken on that edge. Add (command 0) counts one
// occurrence of the normalized word (held at COUNT_MAX), inserts it with
// count 1 when new unless the table is full; read (command 1) returns the
// entry at in_rank of the sorted table. Every command gives one result:
// out_valid is high for exactly one cycle with out_status, out_count,
// out_word_out and out_entries. After the transfer the sequencer runs
// through S_EVAL and S_DONE with busy high; a new command can be taken
// once busy falls. S_EVAL is a parallel compare across all cells
// (registered match and old count); S_DONE shifts the chain.
// The receiver cannot stall; results are not held.
// Reset empties the table at once through the cell valid bits; no sweep.
`default_nettype none
module word_frequency_sorter_core #(
  parameter int MAX_ENTRIES = 256,
  parameter int WORD_BYTES  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_command,
  input  wire logic [wfs_pkg::KEY_W-1:0]    in_word_key,
  input  wire logic [wfs_pkg::RANK_W-1:0]   in_rank,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [wfs_pkg::COUNT_W-1:0]       out_count,
  output logic [wfs_pkg::KEY_W-1:0]         out_word_out,
  output logic [8:0]                        out_entries
);
  localparam int N_W = $clog2(MAX_ENTRIES + 1);
  localparam int C_W = (N_W > wfs_pkg::RANK_W) ? N_W : wfs_pkg::RANK_W;

  wfs_pkg::state_t state_r, state_nxt;
  logic                          cmd_r;
  logic [wfs_pkg::KEY_W-1:0]     key_r;
  logic [wfs_pkg::RANK_W-1:0]    rank_r;
  logic [N_W-1:0]                n_r;
  logic [wfs_pkg::COUNT_W-1:0]   oldcnt_r;
  logic                          found_r;
  logic [wfs_pkg::KEY_W-1:0]     norm;
  logic [wfs_pkg::KEY_W-1:0]     rd_word_r;
  logic [wfs_pkg::COUNT_W-1:0]   rd_cnt_r;
  logic                          out_valid_r;
  logic [1:0]                    status_r;
  logic [wfs_pkg::COUNT_W-1:0]   ocnt_r;
  logic [wfs_pkg::KEY_W-1:0]     oword_r;

  wfs_pkg::cell_ctl_t  ctl;
  wfs_pkg::cell_link_t links [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hits;
  logic [wfs_pkg::COUNT_W-1:0] hit_cnt;

  // normalization: cut at first zero byte and keep WORD_BYTES bytes
  always_comb begin
    logic alive;
    alive = 1'b1;
    norm  = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_word_key[56-8*i +: 8] == 8'd0 || i >= WORD_BYTES) alive = 1'b0;
      if (alive) norm[56-8*i +: 8] = in_word_key[56-8*i +: 8];
    end
  end

  // chain of cells
  assign links[0] = '{valid: 1'b1, after: 1'b0, match: 1'b0,
                      word: '0, cnt: '0};
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    wfs_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                     .prev(links[g]), .link(links[g+1]));
    assign hits[g] = links[g+1].match && !links[g].match;
  end

  // count of the matching cell (one-hot or-reduction)
  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (hits[i]) hit_cnt = hit_cnt | links[i+1].cnt;
  end

  // broadcast in done: commit on add when allowed
  logic full_drop, sat;
  assign full_drop = !found_r && (n_r == N_W'(MAX_ENTRIES));
  assign sat       = found_r && (oldcnt_r == wfs_pkg::COUNT_MAX);
  always_comb begin
    ctl.key = key_r;
    ctl.ins = !found_r;
    ctl.cnt = found_r ? oldcnt_r + 16'd1 : 16'd1;
    ctl.upd = (state_r == wfs_pkg::S_DONE) && (cmd_r == wfs_pkg::CMD_ADD) &&
              !full_drop && !sat;
  end

  // sequencer
  always_comb begin
    case (state_r)
      wfs_pkg::S_IDLE: state_nxt = (start) ? wfs_pkg::S_EVAL : wfs_pkg::S_IDLE;
      wfs_pkg::S_EVAL: state_nxt = wfs_pkg::S_DONE;
      wfs_pkg::S_DONE: state_nxt = wfs_pkg::S_IDLE;
      default:         state_nxt = wfs_pkg::S_IDLE;
    endcase
  end
  assign busy = (state_r != wfs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfs_pkg::S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == wfs_pkg::S_DONE);
      if (ctl.upd && ctl.ins) n_r <= n_r + N_W'(1);
    end
    // capture the command, and in done register the result
    if (state_r == wfs_pkg::S_IDLE && start) begin
      cmd_r  <= in_command;
      key_r  <= norm;
      rank_r <= in_rank;
    end
    if (state_r == wfs_pkg::S_DONE) begin
      if (cmd_r == wfs_pkg::CMD_READ) begin
        if (C_W'(rank_r) < C_W'(n_r)) begin
          status_r <= wfs_pkg::ST_OK;
          ocnt_r   <= rd_cnt_r;
          oword_r  <= rd_word_r;
        end else begin
          status_r <= wfs_pkg::ST_RANK;
          ocnt_r   <= '0;
          oword_r  <= '0;
        end
      end else begin
        status_r <= full_drop ? wfs_pkg::ST_FULL : wfs_pkg::ST_OK;
        ocnt_r   <= full_drop ? '0 : (sat ? oldcnt_r : ctl.cnt);
        oword_r  <= key_r;
      end
    end
  end

  // registered match and read select; done uses the compare made in eval
  always_ff @(posedge clk) begin
    found_r  <= links[MAX_ENTRIES].match;
    oldcnt_r <= hit_cnt;
    rd_word_r <= links[N_W'(rank_r) + N_W'(1)].word;
    rd_cnt_r  <= links[N_W'(rank_r) + N_W'(1)].cnt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_count    = ocnt_r;
  assign out_word_out = oword_r;
  assign out_entries  = 9'(n_r);
endmodule
`default_nettype wire

[hdl/wfs_checker.sv]
// port-level checker for the word frequency sorter, bound to the top level
`default_nettype none
module wfs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic [8:0] out_entries
);
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid) else $error("result latency");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy after transfer");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_ent: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> $stable(out_entries) || $past(start)) else $error("entries moved");
endmodule
bind word_frequency_sorter_core wfs_checker u_wfs_checker (.*);
`default_nettype wire
